@@ src/debounced_input_led_pattern_defines.svh @@
// assertion macros for the debounced input led pattern block
`ifndef DEBOUNCED_INPUT_LED_PATTERN_DEFINES_SVH
`define DEBOUNCED_INPUT_LED_PATTERN_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define DILP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dilp assertion failed");
// condition in one cycle forces a consequence in the next
`define DILP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dilp assertion failed");
`else
`define DILP_ASSERT(lbl, prop)
`define DILP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/dilp_pkg.sv @@
// shared types, constants and helpers of the debounced input led pattern block
package dilp_pkg;

    // event queue depth default
    localparam int QUEUE_DEPTH_DEF = 8;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd3;

    // register reset values
    localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [15:0] BLINK_HALF_RST = 16'd100;
    localparam logic [7:0]  BLINK_CNT_RST  = 8'd3;
    localparam logic [15:0] HOLD_RST       = 16'd500;

    // pattern sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_HOLD = 2'd3
    } phase_t;

    // configuration registers as one bundle
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] blink_half_ticks;
        logic [7:0]  blink_count;
        logic [15:0] hold_ticks;
    } cfg_t;

    // debounced sample from the front end
    typedef struct packed {
        logic published;
        logic level;
    } event_t;

    // head of the event queue as seen by the sequencer
    typedef struct packed {
        logic avail;
        logic level;
    } q_head_t;

    // per-tick sequencer status
    typedef struct packed {
        logic led_on;
        logic busy;
    } seq_out_t;

    // one result item
    typedef struct packed {
        logic led_on;
        logic event_published;
        logic event_level;
        logic event_dropped;
        logic sequencer_busy;
    } result_t;

    // zero timing values act as one
    function automatic logic [15:0] at_least_one16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ src/dilp_ram.sv @@
// generic single write, single read ram with registered read data
module dilp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/dilp_debounce.sv @@
// retriggerable debounce counter that publishes the sampled pin level
module dilp_debounce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic              pin_level,
    input  logic              pin_edge,
    input  logic [15:0]       debounce_ticks,
    output dilp_pkg::event_t  evt
);

    logic [15:0] left_reg;
    logic [15:0] left_next;
    logic        fire;

    // sample when the count runs out without a new edge
    assign fire = !pin_edge && (left_reg == 16'd1);

    always_comb
    begin
        left_next = left_reg;
        if (pin_edge)
        begin
            left_next = dilp_pkg::at_least_one16(debounce_ticks);
        end
        else if (left_reg != 16'd0)
        begin
            left_next = left_reg - 16'd1;
        end
    end

    // counter advances once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 16'd0;
        end
        else if (tick)
        begin
            left_reg <= left_next;
        end
    end

    assign evt.published = fire;
    assign evt.level     = fire & pin_level;

endmodule

@@ src/dilp_event_queue.sv @@
// event queue between the debounce front end and the led sequencer
module dilp_event_queue #(
    parameter int DEPTH = dilp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  dilp_pkg::event_t   evt,
    input  logic               pop,
    output dilp_pkg::q_head_t  head,
    output logic               dropped
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              byp_valid_reg, byp_valid_next;
    logic              byp_data_reg;
    logic              is_full;
    logic              do_push;
    logic              do_pop;
    logic              ram_data;
    logic              stored_level;

    // full check is made before this tick's pop
    assign is_full = (fill_reg >= FULL_FILL);
    assign do_push = tick && evt.published && !is_full;
    assign do_pop  = tick && pop;
    assign dropped = evt.published && is_full;

    // pointer and fill updates
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    // a write to the address being read is forwarded next cycle
    assign byp_valid_next = do_push && (tail_reg == head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= evt.level;
    end

    // entry storage, read address follows the next head
    dilp_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (do_push),
        .wr_addr (tail_reg),
        .wr_data (evt.level),
        .rd_addr (head_next),
        .rd_data (ram_data)
    );

    assign stored_level = byp_valid_reg ? byp_data_reg : ram_data;

    // an empty queue hands over the event pushed in this tick
    assign head.avail = (fill_reg != '0) || do_push;
    assign head.level = (fill_reg == '0) ? evt.level : stored_level;

endmodule

@@ src/dilp_sequencer.sv @@
// led pattern sequencer: blinks for a high event, steady hold for a low one
module dilp_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  dilp_pkg::cfg_t     cfg,
    input  dilp_pkg::q_head_t  head,
    output logic               pop,
    output dilp_pkg::seq_out_t status
);

    dilp_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      timer_reg, timer_next;
    logic [7:0]       blinks_reg, blinks_next;

    // state registers advance once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dilp_pkg::PH_IDLE;
            timer_reg  <= 16'd0;
            blinks_reg <= 8'd0;
        end
        else if (tick)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            blinks_reg <= blinks_next;
        end
    end

    // start a pattern, then play one tick of it
    always_comb
    begin
        logic [15:0] half;
        half          = dilp_pkg::at_least_one16(cfg.blink_half_ticks);
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        blinks_next   = blinks_reg;
        pop           = 1'b0;
        status.led_on = 1'b0;
        status.busy   = 1'b0;

        if (phase_reg == dilp_pkg::PH_IDLE && head.avail)
        begin
            pop = 1'b1;
            if (head.level)
            begin
                phase_next  = dilp_pkg::PH_ON;
                timer_next  = half;
                blinks_next = dilp_pkg::at_least_one8(cfg.blink_count);
            end
            else
            begin
                phase_next = dilp_pkg::PH_HOLD;
                timer_next = dilp_pkg::at_least_one16(cfg.hold_ticks);
            end
        end

        if (phase_next != dilp_pkg::PH_IDLE)
        begin
            status.busy   = 1'b1;
            status.led_on = (phase_next == dilp_pkg::PH_ON) ||
                            (phase_next == dilp_pkg::PH_HOLD);
            if (timer_next != 16'd0)
            begin
                timer_next = timer_next - 16'd1;
            end
            if (timer_next == 16'd0)
            begin
                unique case (phase_next)
                    dilp_pkg::PH_ON:
                    begin
                        phase_next = dilp_pkg::PH_OFF;
                        timer_next = half;
                    end
                    dilp_pkg::PH_OFF:
                    begin
                        if (blinks_next != 8'd0)
                        begin
                            blinks_next = blinks_next - 8'd1;
                        end
                        if (blinks_next != 8'd0)
                        begin
                            phase_next = dilp_pkg::PH_ON;
                            timer_next = half;
                        end
                        else
                        begin
                            phase_next = dilp_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = dilp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

@@ src/debounced_input_led_pattern.sv @@
// top level: config registers, debounce front end, event queue, sequencer, result buffer
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  tick in  | push / full        | pin_level, pin_edge
//  result   | pop / empty        | led_on, event_published, event_level,
//           |                    | event_dropped, sequencer_busy
//  config   | cfg_we             | cfg_index, cfg_data
//
// one tick is taken per clock while full is low, and its result is ready in the next cycle.
// debounce, queue and sequencer update together in the cycle the tick is transferred.
// a two-entry result buffer sets full; a tick is taken while one result waits.
// reset clears all counters, the queue pointers and the result buffer at once.
module debounced_input_led_pattern #(
    parameter int QUEUE_DEPTH = dilp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           pin_level,
    input  logic                           pin_edge,
    output logic                           empty,
    input  logic                           pop,
    output logic                           led_on,
    output logic                           event_published,
    output logic                           event_level,
    output logic                           event_dropped,
    output logic                           sequencer_busy,
    input  logic                           cfg_we,
    input  logic [dilp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dilp_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "debounced_input_led_pattern_defines.svh"

    dilp_pkg::cfg_t     cfg_reg;
    dilp_pkg::event_t   evt;
    dilp_pkg::q_head_t  q_head;
    dilp_pkg::seq_out_t seq_status;
    dilp_pkg::result_t  res;
    logic               tick;
    logic               seq_pop;
    logic               q_dropped;
    logic               out_take;

    dilp_pkg::result_t  ob_data_reg [2];
    logic               ob_wr_reg;
    logic               ob_rd_reg;
    logic [1:0]         ob_count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= dilp_pkg::DEBOUNCE_RST;
            cfg_reg.blink_half_ticks <= dilp_pkg::BLINK_HALF_RST;
            cfg_reg.blink_count      <= dilp_pkg::BLINK_CNT_RST;
            cfg_reg.hold_ticks       <= dilp_pkg::HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dilp_pkg::CFG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                dilp_pkg::CFG_BLINK_HALF: cfg_reg.blink_half_ticks <= cfg_data;
                dilp_pkg::CFG_BLINK_CNT:  cfg_reg.blink_count      <= cfg_data[7:0];
                dilp_pkg::CFG_HOLD:       cfg_reg.hold_ticks       <= cfg_data;
                default:                  cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // tick transfer
    assign full     = (ob_count_reg == 2'd2);
    assign empty    = (ob_count_reg == 2'd0);
    assign tick     = push && !full;
    assign out_take = pop && !empty;

    // front end
    dilp_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .pin_level      (pin_level),
        .pin_edge       (pin_edge),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .evt            (evt)
    );

    dilp_event_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .evt     (evt),
        .pop     (seq_pop),
        .head    (q_head),
        .dropped (q_dropped)
    );

    // back end
    dilp_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cfg    (cfg_reg),
        .head   (q_head),
        .pop    (seq_pop),
        .status (seq_status)
    );

    // assemble the result of this tick
    assign res.led_on          = seq_status.led_on;
    assign res.event_published = evt.published;
    assign res.event_level     = evt.level;
    assign res.event_dropped   = q_dropped;
    assign res.sequencer_busy  = seq_status.busy;

    // two-entry result buffer
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            ob_data_reg[ob_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg    <= 1'b0;
            ob_rd_reg    <= 1'b0;
            ob_count_reg <= 2'd0;
        end
        else
        begin
            if (tick)
            begin
                ob_wr_reg <= ~ob_wr_reg;
            end
            if (out_take)
            begin
                ob_rd_reg <= ~ob_rd_reg;
            end
            unique case ({tick, out_take})
                2'b10:   ob_count_reg <= ob_count_reg + 2'd1;
                2'b01:   ob_count_reg <= ob_count_reg - 2'd1;
                default: ob_count_reg <= ob_count_reg;
            endcase
        end
    end

    assign led_on          = ob_data_reg[ob_rd_reg].led_on;
    assign event_published = ob_data_reg[ob_rd_reg].event_published;
    assign event_level     = ob_data_reg[ob_rd_reg].event_level;
    assign event_dropped   = ob_data_reg[ob_rd_reg].event_dropped;
    assign sequencer_busy  = ob_data_reg[ob_rd_reg].sequencer_busy;

    // checks
    `DILP_ASSERT(a_drop_needs_sample, !(tick && q_dropped) || evt.published)
    `DILP_ASSERT(a_pop_needs_event, !(tick && seq_pop) || q_head.avail)
    `DILP_ASSERT(a_ob_count_bound, ob_count_reg <= 2'd2)
    `DILP_ASSERT_NEXT(a_tick_gives_result, tick, !empty)

endmodule

@@ sim/tb.sv @@
// testbench for the debounced input led pattern block: tick table plus random pin gestures
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dilp_pkg::*;

    localparam int QDEPTH     = QUEUE_DEPTH_DEF;
    localparam int CYCLE_CAP  = 2_000_000;
    localparam int DRAIN_WAIT = 4;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
    // would land on blink_half if the top index bit were dropped
    localparam logic [CFG_IDX_W-1:0] CFG_ALIAS_HALF  = 3'd5;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    // one row of the directed table: a tick or a register write
    typedef struct packed {
        row_kind_t               kind;
        logic                    lvl;
        logic                    edg;
        logic                    typed;
        result_t                 res;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } dir_row_t;

    // result bits: led_on, event_published, event_level, event_dropped, sequencer_busy
    localparam int DIR_N = 30;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // zero timing values act as one, blink count data is masked to 8 bits
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_BLINK_HALF, 16'h0000},
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_BLINK_CNT,  16'h0100},
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_HOLD,       16'h0000},
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_ALIAS_HALF, 16'hFFFF},
        // idle, edge, sample high with one short blink
        '{ROW_TICK, 1'b0, 1'b0, 1'b1, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b1, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b0, 1'b1, 5'b11101, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b1, 5'b00001, CFG_DEBOUNCE,   16'h0000},
        // long hold so the event queue overflows
        '{ROW_CFG,  1'b0, 1'b0, 1'b0, 5'b00000, CFG_HOLD,       16'd40},
        '{ROW_TICK, 1'b0, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b0, 1'b0, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        '{ROW_TICK, 1'b1, 1'b1, 1'b0, 5'b00000, CFG_DEBOUNCE,   16'h0000},
        // tenth sample finds eight events waiting and is lost
        '{ROW_TICK, 1'b1, 1'b0, 1'b1, 5'b11111, CFG_DEBOUNCE,   16'h0000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  pin_level;
    logic                  pin_edge;
    logic                  empty;
    logic                  pop;
    logic                  led_on;
    logic                  event_published;
    logic                  event_level;
    logic                  event_dropped;
    logic                  sequencer_busy;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    debounced_input_led_pattern dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .pin_level       (pin_level),
        .pin_edge        (pin_edge),
        .empty           (empty),
        .pop             (pop),
        .led_on          (led_on),
        .event_published (event_published),
        .event_level     (event_level),
        .event_dropped   (event_dropped),
        .sequencer_busy  (sequencer_busy),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // predictor copy of registers and state
    logic [15:0] debounce_r;
    logic [15:0] half_r;
    logic [7:0]  count_r;
    logic [15:0] hold_r;
    logic [15:0] settle_left;
    logic        level_fifo [QDEPTH];
    int          fifo_head;
    int          fifo_tail;
    int          fifo_fill;
    phase_t      led_phase;
    logic [15:0] led_timer;
    logic [7:0]  blinks_rem;

    result_t     awaited_frames [$];
    logic        row_typed;
    result_t     row_typed_res;
    int          failures;
    int          ticks_sent;
    int          burst_left;
    int          cycle_count;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [15:0] one_if_zero(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // outputs of one tick; advances the predictor state
    function automatic result_t led_tick_outcome(input logic lvl, input logic edg);
        result_t r;
        logic    head_lvl;
        r = '0;
        // retriggerable debounce
        if (edg)
        begin
            settle_left = one_if_zero(debounce_r);
        end
        else if (settle_left != 16'd0)
        begin
            settle_left = settle_left - 16'd1;
            if (settle_left == 16'd0)
            begin
                r.event_published = 1'b1;
                r.event_level     = lvl;
            end
        end
        // enqueue, full check before this tick's pop
        if (r.event_published)
        begin
            if (fifo_fill >= QDEPTH)
            begin
                r.event_dropped = 1'b1;
            end
            else
            begin
                level_fifo[fifo_tail] = lvl;
                fifo_tail = (fifo_tail + 1) % QDEPTH;
                fifo_fill++;
            end
        end
        // start a pattern from the queue head
        if (led_phase == PH_IDLE && fifo_fill != 0)
        begin
            head_lvl  = level_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % QDEPTH;
            fifo_fill--;
            if (head_lvl)
            begin
                led_phase  = PH_ON;
                led_timer  = one_if_zero(half_r);
                blinks_rem = (count_r == 8'd0) ? 8'd1 : count_r;
            end
            else
            begin
                led_phase = PH_HOLD;
                led_timer = one_if_zero(hold_r);
            end
        end
        // play one pattern tick
        if (led_phase != PH_IDLE)
        begin
            r.sequencer_busy = 1'b1;
            r.led_on = (led_phase == PH_ON || led_phase == PH_HOLD);
            if (led_timer != 16'd0)
                led_timer = led_timer - 16'd1;
            if (led_timer == 16'd0)
            begin
                case (led_phase)
                    PH_ON:
                    begin
                        led_phase = PH_OFF;
                        led_timer = one_if_zero(half_r);
                    end
                    PH_OFF:
                    begin
                        if (blinks_rem != 8'd0)
                            blinks_rem = blinks_rem - 8'd1;
                        if (blinks_rem != 8'd0)
                        begin
                            led_phase = PH_ON;
                            led_timer = one_if_zero(half_r);
                        end
                        else
                        begin
                            led_phase = PH_IDLE;
                        end
                    end
                    default: led_phase = PH_IDLE;
                endcase
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0b, got %0b", name, want, got);
            failures++;
        end
    endtask

    // monitor: register writes, tick transfers and result transfers
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            debounce_r  = DEBOUNCE_RST;
            half_r      = BLINK_HALF_RST;
            count_r     = BLINK_CNT_RST;
            hold_r      = HOLD_RST;
            settle_left = 16'd0;
            fifo_head   = 0;
            fifo_tail   = 0;
            fifo_fill   = 0;
            led_phase   = PH_IDLE;
            led_timer   = 16'd0;
            blinks_rem  = 8'd0;
            for (int i = 0; i < QDEPTH; i++)
                level_fifo[i] = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:   debounce_r = cfg_data;
                    CFG_BLINK_HALF: half_r     = cfg_data;
                    CFG_BLINK_CNT:  count_r    = cfg_data[7:0];
                    CFG_HOLD:       hold_r     = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                want = led_tick_outcome(pin_level, pin_edge);
                if (row_typed)
                    want = row_typed_res;
                awaited_frames.push_back(want);
            end
            if (pop && !empty)
            begin
                got = {led_on, event_published, event_level, event_dropped, sequencer_busy};
                if (awaited_frames.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    failures++;
                end
                else
                begin
                    want = awaited_frames.pop_front();
                    check_field("led_on", want.led_on, got.led_on);
                    check_field("event_published", want.event_published, got.event_published);
                    check_field("event_level", want.event_level, got.event_level);
                    check_field("event_dropped", want.event_dropped, got.event_dropped);
                    check_field("sequencer_busy", want.sequencer_busy, got.sequencer_busy);
                end
            end
        end
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: stall pattern in runs of random mode
    initial
    begin : receiver
        int run_left;
        int mode;
        run_left = 0;
        mode     = 0;
        pop      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 30);
                mode     = $urandom_range(0, 3);
            end
            run_left--;
            case (mode)
                0:       pop = 1'b1;
                1:       pop = ($urandom_range(0, 3) != 0);
                2:       pop = 1'($urandom_range(0, 1));
                default: pop = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // one tick transfer, sent in bursts with random gaps
    task automatic send_tick(input logic lvl, input logic edg);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                push = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push      = 1'b1;
        pin_level = lvl;
        pin_edge  = edg;
        do @(posedge clk); while (full);
        ticks_sent++;
        @(negedge clk);
    endtask

    // register write once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        push = 1'b0;
        while (awaited_frames.size() != 0) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // button presses with bounce, plus noise and cut-short presses
    task automatic run_gestures(input int n_ticks, input logic [15:0] db);
        int   start;
        int   settle;
        int   bounces;
        int   pick;
        int   b;
        logic lvl;
        start  = ticks_sent;
        settle = (db == 16'd0) ? 1 : int'(db);
        while (ticks_sent - start < n_ticks)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                bounces = $urandom_range(1, 4);
                lvl = 1'b0;
                for (b = 0; b < bounces; b++)
                begin
                    lvl = 1'($urandom_range(0, 1));
                    send_tick(lvl, 1'b1);
                    if (b != bounces - 1)
                        repeat ($urandom_range(0, settle - 1))
                            send_tick(1'($urandom_range(0, 1)), 1'b0);
                end
                repeat (settle + $urandom_range(0, 8)) send_tick(lvl, 1'b0);
            end
            else if (pick < 9)
            begin
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0));
            end
            else
            begin
                send_tick(1'($urandom_range(0, 1)), 1'b1);
                repeat ($urandom_range(0, settle - 1))
                    send_tick(1'($urandom_range(0, 1)), 1'b0);
            end
        end
    endtask

    function automatic logic [15:0] pick_timing(input int span);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'($urandom_range(2, span));
        endcase
    endfunction

    // stimulus
    initial
    begin : stimulus
        logic [15:0] db;
        logic        lvl;
        push          = 1'b0;
        pin_level     = 1'b0;
        pin_edge      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DEBOUNCE;
        cfg_data      = '0;
        row_typed     = 1'b0;
        row_typed_res = '0;
        failures      = 0;
        ticks_sent    = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < DIR_N; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end
            else
            begin
                row_typed     = DIR_ROWS[r].typed;
                row_typed_res = DIR_ROWS[r].res;
                send_tick(DIR_ROWS[r].lvl, DIR_ROWS[r].edg);
            end
        end
        row_typed = 1'b0;

        // random settings, small timing so the queue fills and drains
        repeat (9)
        begin
            db = pick_timing(8);
            write_reg(CFG_DEBOUNCE, db);
            write_reg(CFG_BLINK_HALF, pick_timing(12));
            write_reg(CFG_BLINK_CNT, 16'(($urandom_range(0, 255) << 8) | $urandom_range(0, 5)));
            write_reg(CFG_HOLD, pick_timing(60));
            if ($urandom_range(0, 1) == 1)
                write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 16'($urandom));
            run_gestures(90, db);
        end

        // longest blink train
        write_reg(CFG_DEBOUNCE, 16'd2);
        write_reg(CFG_BLINK_HALF, 16'd1);
        write_reg(CFG_BLINK_CNT, 16'h00FF);
        write_reg(CFG_HOLD, 16'd1);
        run_gestures(200, 16'd2);

        // all registers at their maximum, edges keep reloading the long debounce time
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_BLINK_HALF, 16'hFFFF);
        write_reg(CFG_BLINK_CNT, 16'hFFFF);
        write_reg(CFG_HOLD, 16'hFFFF);
        lvl = 1'($urandom_range(0, 1));
        send_tick(~lvl, 1'b1);
        send_tick(lvl, 1'b0);
        send_tick(lvl, 1'b1);
        repeat (100) send_tick(lvl, 1'b0);
        repeat (40) send_tick(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));

        // drain and finish
        push = 1'b0;
        while (awaited_frames.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
